>>> hw/rtl/sgpg_pkg.sv
// Shared types, constants and the 3x5 glyph table for the scaled glyph pixel generator.
`default_nettype none

package sgpg_pkg;

  localparam int unsigned COORD_BITS = 12;
  localparam logic [COORD_BITS-1:0] COORD_MAX = '1;
  localparam int unsigned SCALE_W = 2;
  localparam int unsigned CELLS = 15;
  localparam int unsigned GLYPHS = 36;
  localparam int unsigned OFF_W = 4;

  localparam logic [7:0] CHAR_A = 8'h41;
  localparam logic [7:0] CHAR_Z = 8'h5A;
  localparam logic [7:0] CHAR_0 = 8'h30;
  localparam logic [7:0] CHAR_9 = 8'h39;
  localparam logic [5:0] DIGIT_BASE = 6'd26;

  typedef struct packed {
    logic [7:0]            char_code;
    logic                  first_of_word;
    logic [COORD_BITS-1:0] start_x;
    logic [COORD_BITS-1:0] start_y;
    logic [SCALE_W-1:0]    scale;
    logic [15:0]           ink_color;
  } sgpg_in_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
    logic [15:0]           pixel_color;
    logic                  last_pixel;
  } sgpg_out_t;

  typedef struct packed {
    logic load;
    logic advance;
    logic emit;
  } sgpg_cmd_t;

  typedef struct packed {
    logic done;
    logic cell_set;
    logic slot_free;
  } sgpg_status_t;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } sgpg_state_t;

  // Row-major cells, top row first; MSB is the top-left cell.
  localparam logic [CELLS-1:0] GLYPH_ROM [GLYPHS] = '{
    15'b111_101_111_101_101, 15'b111_101_110_101_111, // A B
    15'b111_100_100_100_111, 15'b110_101_101_101_110, // C D
    15'b111_100_110_100_111, 15'b111_100_110_100_100, // E F
    15'b111_100_101_101_111, 15'b101_101_111_101_101, // G H
    15'b111_010_010_010_111, 15'b111_001_001_101_111, // I J
    15'b101_110_110_101_101, 15'b100_100_100_100_111, // K L
    15'b101_111_101_101_101, 15'b111_101_101_101_101, // M N
    15'b111_101_101_101_111, 15'b110_101_111_100_100, // O P
    15'b010_101_101_110_011, 15'b111_101_111_110_101, // Q R
    15'b011_100_010_001_110, 15'b111_010_010_010_010, // S T
    15'b101_101_101_101_111, 15'b101_101_101_101_010, // U V
    15'b101_101_101_111_101, 15'b101_101_010_101_101, // W X
    15'b101_101_010_010_010, 15'b111_001_010_100_111, // Y Z
    15'b111_101_101_101_111, 15'b010_110_010_010_111, // 0 1
    15'b111_001_111_100_111, 15'b111_001_111_001_111, // 2 3
    15'b101_101_111_001_001, 15'b111_100_111_001_111, // 4 5
    15'b111_100_111_101_111, 15'b111_001_001_001_001, // 6 7
    15'b111_101_111_101_111, 15'b111_101_111_001_111  // 8 9
  };

  function automatic logic [CELLS-1:0] glyph_mask(input logic [7:0] code);
    logic [7:0] letter;
    logic [7:0] digit;
    logic [CELLS-1:0] mask;
    letter = code - CHAR_A;
    digit  = code - CHAR_0;
    mask   = '0;
    if (code >= CHAR_A && code <= CHAR_Z) begin
      mask = GLYPH_ROM[letter[5:0]];
    end else if (code >= CHAR_0 && code <= CHAR_9) begin
      mask = GLYPH_ROM[DIGIT_BASE + digit[5:0]];
    end
    return mask;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/sgpg_ctrl.sv
// Sequencer: accepts a character, then walks its glyph cells and paces pixel transfers.
`default_nettype none

module sgpg_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire sgpg_pkg::sgpg_status_t status,
  output sgpg_pkg::sgpg_cmd_t        cmd
);
  import sgpg_pkg::*;

  sgpg_state_t state;
  sgpg_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    in_ready    = 1'b0;
    cmd.load    = 1'b0;
    cmd.advance = 1'b0;
    cmd.emit    = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (status.done) begin
          state_next = ST_IDLE;
        end else if (!status.cell_set) begin
          cmd.advance = 1'b1;
        end else if (status.slot_free) begin
          cmd.emit    = 1'b1;
          cmd.advance = 1'b1;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> hw/rtl/sgpg_datapath.sv
// Datapath: pen, glyph cell mask, scan counters, coordinate math and output register.
`default_nettype none

module sgpg_datapath #(
  parameter int unsigned MAX_SCALE = 2
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire sgpg_pkg::sgpg_in_t    in_data,
  input  wire sgpg_pkg::sgpg_cmd_t   cmd,
  output sgpg_pkg::sgpg_status_t     status,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output sgpg_pkg::sgpg_out_t        out_data
);
  import sgpg_pkg::*;

  localparam logic [SCALE_W-1:0] SCALE_LIM = SCALE_W'(MAX_SCALE);

  logic [COORD_BITS-1:0] pen;
  logic [COORD_BITS-1:0] x0;
  logic [COORD_BITS-1:0] y0;
  logic [15:0]           color;
  logic [SCALE_W-1:0]    scale;
  logic [CELLS-1:0]      mask;
  logic [2:0]            row;
  logic [1:0]            col;
  logic [SCALE_W-1:0]    dx;
  logic [SCALE_W-1:0]    dy;

  logic [SCALE_W-1:0]    scale_eff;
  logic [COORD_BITS-1:0] x_draw;
  logic [COORD_BITS:0]   pen_sum;
  logic [SCALE_W-1:0]    scale_m1;
  logic                  dx_end;
  logic                  pix_end;
  logic [OFF_W-1:0]      x_off;
  logic [OFF_W-1:0]      y_off;
  logic [COORD_BITS:0]   x_sum;
  logic [COORD_BITS:0]   y_sum;
  sgpg_out_t             pixel;

  assign scale_eff = (in_data.scale > SCALE_LIM) ? SCALE_LIM : in_data.scale;
  assign x_draw    = in_data.first_of_word ? in_data.start_x : pen;
  assign pen_sum   = (COORD_BITS+1)'(x_draw) + (COORD_BITS+1)'({scale_eff, 2'b00});

  assign scale_m1 = scale - SCALE_W'(1);
  assign dx_end   = (dx == scale_m1);
  assign pix_end  = dx_end && (dy == scale_m1);

  assign x_off = OFF_W'(col) * OFF_W'(scale) + OFF_W'(dx);
  assign y_off = OFF_W'(row) * OFF_W'(scale) + OFF_W'(dy);
  assign x_sum = (COORD_BITS+1)'(x0) + (COORD_BITS+1)'(x_off);
  assign y_sum = (COORD_BITS+1)'(y0) + (COORD_BITS+1)'(y_off);

  always_comb begin
    pixel.pixel_x     = x_sum[COORD_BITS] ? COORD_MAX : x_sum[COORD_BITS-1:0];
    pixel.pixel_y     = y_sum[COORD_BITS] ? COORD_MAX : y_sum[COORD_BITS-1:0];
    pixel.pixel_color = color;
    // last lit pixel: final square position and no lit cells left behind this one
    pixel.last_pixel  = pix_end && (mask[CELLS-2:0] == '0);
  end

  assign status.done      = (mask == '0);
  assign status.cell_set  = mask[CELLS-1];
  assign status.slot_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pen  <= '0;
      mask <= '0;
    end else if (cmd.load) begin
      pen  <= pen_sum[COORD_BITS] ? COORD_MAX : pen_sum[COORD_BITS-1:0];
      mask <= (scale_eff == '0) ? '0 : glyph_mask(in_data.char_code);
    end else if (cmd.advance && !(mask[CELLS-1] && !pix_end)) begin
      mask <= {mask[CELLS-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x0    <= x_draw;
      y0    <= in_data.start_y;
      color <= in_data.ink_color;
      scale <= scale_eff;
      row   <= '0;
      col   <= '0;
      dx    <= '0;
      dy    <= '0;
    end else if (cmd.advance) begin
      if (mask[CELLS-1] && !pix_end) begin
        if (dx_end) begin
          dx <= '0;
          dy <= dy + SCALE_W'(1);
        end else begin
          dx <= dx + SCALE_W'(1);
        end
      end else begin
        dx <= '0;
        dy <= '0;
        if (col == 2'd2) begin
          col <= '0;
          row <= row + 3'd1;
        end else begin
          col <= col + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data <= pixel;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/scaled_glyph_pixel_generator.sv
// Top level of the scaled 3x5 glyph pixel generator.
`default_nettype none

// Takes one character per input transfer and emits one output transfer per pixel
// to set, for every lit cell of its 3x5 glyph (A-Z, 0-9), each cell drawn as a
// scale-by-scale square, rows top to bottom, then columns, then dy, then dx.
// Other codes and scale zero emit nothing but still move the pen, which advances
// by 4 * scale after every character (start_x is used when first_of_word is set).
// Scale is clamped to MAX_SCALE; coordinates and pen saturate at 4095.
// One character at a time: the sequencer accepts it, then steps over each unlit cell
// ahead of the last lit cell and through every pixel of each lit cell, holding while
// a pixel waits untaken in the output register, then finishes. The output register
// lets the next character be accepted while the final pixel waits.

module scaled_glyph_pixel_generator #(
  parameter int unsigned MAX_SCALE = 2
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire sgpg_pkg::sgpg_in_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output sgpg_pkg::sgpg_out_t      out_data
);
  import sgpg_pkg::*;

  sgpg_cmd_t    cmd;
  sgpg_status_t status;

  sgpg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  sgpg_datapath #(
    .MAX_SCALE (MAX_SCALE)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
